// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the ready queue dispatcher RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define RQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies consequence in the next
`define RQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/rqtd_pkg.sv -----
// Shared types and constants of the ready queue task dispatcher.
// No dependencies; used by the cell and the top level.
package rqtd_pkg;

  localparam int QueueDepth = 4;

  // policy register codes
  localparam logic [1:0] ModeFifo = 2'd0;
  localparam logic [1:0] ModeEdf  = 2'd1;
  localparam logic [1:0] ModeRm   = 2'd2;

  // command codes
  localparam logic CmdEnq  = 1'b0;
  localparam logic CmdDisp = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  task_id;
    logic [31:0] task_deadline;
    logic [31:0] task_period;
    logic        busy_req;
  } in_beat_t;

  typedef struct packed {
    logic       grant_valid;
    logic [3:0] grant_task;
    logic       overflow;
    logic [4:0] queue_count;
  } out_beat_t;

  // one queue entry held by a cell
  typedef struct packed {
    logic [3:0]  tid;
    logic [31:0] deadline;
    logic [31:0] period;
  } entry_t;

  // running minimum handed from cell to cell during a search
  typedef struct packed {
    logic        active;
    logic        has;
    logic [31:0] key;
    logic [3:0]  tid;
  } sweep_t;

endpackage

// ----- hdl/rqtd_stream_if.sv -----
// Valid/ready stream interface carrying one payload beat.
// Payload type is a parameter; used with rqtd_pkg beat types.
interface rqtd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/rqtd_cell.sv -----
// One queue slot: holds an entry, shifts toward the head on removal,
// and takes part in the minimum search. Depends on rqtd_pkg.
module rqtd_cell #(
  parameter int IDX   = 0,
  parameter int POS_W = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              occ,
  input  logic              key_sel_dl,
  input  logic              wr_en,
  input  rqtd_pkg::entry_t  wr_data,
  input  logic              shift_en,
  input  rqtd_pkg::entry_t  nbr_entry,
  input  rqtd_pkg::sweep_t  sweep_i,
  input  logic [POS_W-1:0]  pos_i,
  output rqtd_pkg::entry_t  entry_o,
  output rqtd_pkg::sweep_t  sweep_o,
  output logic [POS_W-1:0]  pos_o
);

  rqtd_pkg::entry_t entry_r;
  rqtd_pkg::sweep_t sweep_r, sweep_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      own_key;
  logic             take;

  // compare own key against the running minimum; strict less keeps the oldest
  always_comb begin
    own_key   = key_sel_dl ? entry_r.deadline : entry_r.period;
    take      = sweep_i.active && occ && (!sweep_i.has || (own_key < sweep_i.key));
    sweep_nxt = sweep_i;
    pos_nxt   = pos_i;
    if (take) begin
      sweep_nxt.has = 1'b1;
      sweep_nxt.key = own_key;
      sweep_nxt.tid = entry_r.tid;
      pos_nxt       = POS_W'(IDX);
    end
  end

  // search token (reset), search payload and entry storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r.active <= 1'b0;
    end else begin
      sweep_r.active <= sweep_nxt.active;
    end
    sweep_r.has <= sweep_nxt.has;
    sweep_r.key <= sweep_nxt.key;
    sweep_r.tid <= sweep_nxt.tid;
    pos_r       <= pos_nxt;
    if (wr_en) begin
      entry_r <= wr_data;
    end else if (shift_en) begin
      entry_r <= nbr_entry;
    end
  end

  assign entry_o = entry_r;
  assign sweep_o = sweep_r;
  assign pos_o   = pos_r;

endmodule

// ----- hdl/ready_queue_task_dispatcher_top.sv -----
// Ready queue task dispatcher: FIFO, EDF or rate monotonic pick over a row of cells.
// An enqueue or a blocked dispatch goes straight to the done state, a FIFO dispatch
// passes through the shift state, and an EDF or rate monotonic dispatch through the
// scan and shift states, the search token walking the cell row one cell per cycle. The
// next beat is taken the cycle after the result is registered. Synchronous active-low
// reset empties the queue and sets FIFO policy; entry contents are not cleared.
`include "assert_macros.svh"

module ready_queue_task_dispatcher_top #(
  parameter int QUEUE_DEPTH = rqtd_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  rqtd_stream_if.sink          in_ch,
  rqtd_stream_if.source        out_ch
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [1:0]            policy_r;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  res_grant_r, res_grant_nxt;
  logic [3:0]            res_task_r, res_task_nxt;
  logic                  res_ovf_r, res_ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rqtd_pkg::out_beat_t   out_beat_r, out_beat_nxt;

  logic                  in_acc, is_enq, full, enq_ok, disp_ok;
  logic                  use_scan, key_sel_dl, scan_start, out_free;
  rqtd_pkg::entry_t      wr_data;
  rqtd_pkg::entry_t      cell_entry [QUEUE_DEPTH];
  rqtd_pkg::sweep_t      sweep      [QUEUE_DEPTH+1];
  logic [POS_W-1:0]      pos_chain  [QUEUE_DEPTH+1];

  // handshake and command decode
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_enq      = (in_ch.data.cmd == rqtd_pkg::CmdEnq);
  assign full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign enq_ok      = in_acc && is_enq && !full;
  assign disp_ok     = in_acc && !is_enq && !in_ch.data.busy_req && (count_r != '0);
  assign out_free    = !out_valid_r || out_ch.ready;

  assign wr_data.tid      = in_ch.data.task_id;
  assign wr_data.deadline = in_ch.data.task_deadline;
  assign wr_data.period   = in_ch.data.task_period;

  // policy decode; unused code behaves as FIFO
  always_comb begin
    case (policy_r)
      rqtd_pkg::ModeEdf: begin
        use_scan   = 1'b1;
        key_sel_dl = 1'b1;
      end
      rqtd_pkg::ModeRm: begin
        use_scan   = 1'b1;
        key_sel_dl = 1'b0;
      end
      default: begin
        use_scan   = 1'b0;
        key_sel_dl = 1'b0;
      end
    endcase
  end

  assign scan_start = disp_ok && use_scan;

  // head of the search chain
  assign sweep[0]     = '{active: scan_start, has: 1'b0, key: '0, tid: '0};
  assign pos_chain[0] = '0;

  // row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    rqtd_pkg::entry_t nbr;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr = cell_entry[i];
    end else begin : g_mid
      assign nbr = cell_entry[i+1];
    end

    rqtd_cell #(
      .IDX   (i),
      .POS_W (POS_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .occ        (CNT_W'(i) < count_r),
      .key_sel_dl (key_sel_dl),
      .wr_en      (enq_ok && (count_r == CNT_W'(i))),
      .wr_data    (wr_data),
      .shift_en   ((state_r == ST_SHIFT) && (CNT_W'(i) >= CNT_W'(pos_r))),
      .nbr_entry  (nbr),
      .sweep_i    (sweep[i]),
      .pos_i      (pos_chain[i]),
      .entry_o    (cell_entry[i]),
      .sweep_o    (sweep[i+1]),
      .pos_o      (pos_chain[i+1])
    );
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    res_grant_nxt = res_grant_r;
    res_task_nxt  = res_task_r;
    res_ovf_nxt   = res_ovf_r;
    out_beat_nxt  = out_beat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_grant_nxt = 1'b0;
          res_task_nxt  = '0;
          res_ovf_nxt   = 1'b0;
          state_nxt     = ST_DONE;
          if (is_enq) begin
            res_ovf_nxt = full;
            if (!full) begin
              count_nxt = count_r + 1'b1;
            end
          end else if (disp_ok) begin
            if (use_scan) begin
              state_nxt = ST_SCAN;
            end else begin
              pos_nxt       = '0;
              res_grant_nxt = 1'b1;
              res_task_nxt  = cell_entry[0].tid;
              state_nxt     = ST_SHIFT;
            end
          end
        end
      end
      ST_SCAN: begin
        if (sweep[QUEUE_DEPTH].active) begin
          pos_nxt       = pos_chain[QUEUE_DEPTH];
          res_grant_nxt = 1'b1;
          res_task_nxt  = sweep[QUEUE_DEPTH].tid;
          state_nxt     = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        count_nxt = count_r - 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_beat_nxt.grant_valid = res_grant_r;
          out_beat_nxt.grant_task  = res_task_r;
          out_beat_nxt.overflow    = res_ovf_r;
          out_beat_nxt.queue_count = 5'(count_r);
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      policy_r    <= rqtd_pkg::ModeFifo;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    res_grant_r <= res_grant_nxt;
    res_task_r  <= res_task_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_beat_r  <= out_beat_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_beat_r;

  // checks
  `RQ_ASSERT(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
  `RQ_ASSERT(a_shift_nonempty, (state_r == ST_SHIFT) |-> (count_r != '0), "removal from empty queue")
  `RQ_ASSERT_NEXT(a_shift_dec, state_r == ST_SHIFT, count_r == CNT_W'($past(count_r) - 1'b1), "count not decremented")
  `RQ_ASSERT(a_out_excl, out_valid_r |-> !(out_beat_r.grant_valid && out_beat_r.overflow), "grant and overflow together")
  `RQ_ASSERT(a_idle_chain, (state_r == ST_IDLE) |-> !sweep[QUEUE_DEPTH].active, "search token live while idle")

endmodule
